// ----- rtl/conv2d_valid_window_assert.svh -----
// Assertion macros shared by the conv2d_valid_window RTL
`ifndef CONV2D_VALID_WINDOW_ASSERT_SVH
`define CONV2D_VALID_WINDOW_ASSERT_SVH

// same-cycle implication, disabled in reset
`define C2DV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("conv2d_valid_window: assertion failed");

// next-cycle implication, disabled in reset
`define C2DV_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("conv2d_valid_window: assertion failed");

`endif

// ----- rtl/c2dv_pkg.sv -----
// Shared types and constants of the 2D valid-window correlator
`timescale 1ns / 1ps
`default_nettype none

package c2dv_pkg;

  localparam int IMG_W       = 9;
  localparam int KDIM_W      = 3;
  localparam int COEF_W      = 16;
  localparam int COEF_IDX_W  = 5;
  localparam int CONV_W      = 36;
  localparam int COORD_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int OUT_TDATA_W = ((CONV_W + 2 * COORD_W + 7) / 8) * 8;

  localparam logic [IMG_W-1:0]  IMG_COLS_RST = IMG_W'(28);
  localparam logic [IMG_W-1:0]  IMG_ROWS_RST = IMG_W'(28);
  localparam logic [KDIM_W-1:0] KDIM_RST     = KDIM_W'(3);

  typedef enum logic {
    CMD_COEF   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_COLS  = 2'd0,
    CFG_IMAGE_ROWS  = 2'd1,
    CFG_KERNEL_ROWS = 2'd2,
    CFG_KERNEL_COLS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic shift;
    logic prod;
    logic sum;
  } cell_ctrl_t;

  typedef struct packed {
    logic               frame_last;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
  } res_meta_t;

endpackage

`default_nettype wire

// ----- rtl/c2dv_ram.sv -----
// Simple dual-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module c2dv_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/c2dv_cell.sv -----
// One window column cell: column register, row products and column sum
`timescale 1ns / 1ps
`default_nettype none

module c2dv_cell
  import c2dv_pkg::*;
#(
  parameter int MAX_KERNEL  = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                          clk_i,
  input  cell_ctrl_t                                    ctrl_i,
  input  logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0]        col_i,
  input  logic [MAX_KERNEL-1:0][COEF_W-1:0]             coef_i,
  input  logic [MAX_KERNEL-1:0]                         row_en_i,
  output logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0]        col_o,
  output logic signed [SAMPLE_BITS+COEF_W+$clog2(MAX_KERNEL)-1:0] sum_o
);

  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam int SUM_W  = PROD_W + $clog2(MAX_KERNEL);

  logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] col_q;
  logic signed [PROD_W-1:0]               prod_d [MAX_KERNEL];
  logic signed [PROD_W-1:0]               prod_q [MAX_KERNEL];
  logic signed [SUM_W-1:0]                sum_d;
  logic signed [SUM_W-1:0]                sum_q;

  always_comb begin
    for (int r = 0; r < MAX_KERNEL; r++) begin
      prod_d[r] = $signed(col_q[r]) * $signed(coef_i[r]);
      if (!row_en_i[r]) begin
        prod_d[r] = '0;
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int r = 0; r < MAX_KERNEL; r++) begin
      sum_d = sum_d + SUM_W'(prod_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      col_q <= col_i;
    end
    if (ctrl_i.prod) begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
        prod_q[r] <= prod_d[r];
      end
    end
    if (ctrl_i.sum) begin
      sum_q <= sum_d;
    end
  end

  assign col_o = col_q;
  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ----- rtl/conv2d_valid_window.sv -----
// Top level of the streaming valid-region 2D cross-correlator
`timescale 1ns / 1ps
`default_nettype none
`include "conv2d_valid_window_assert.svh"

// Streams a raster image one sample per transaction and emits one exact, unrounded
// valid-region cross-correlation result per complete window, tagged with its output
// coordinates and an end-of-frame flag on tlast. The block sustains one item per
// cycle unless m_axis_tready stalls the result port. A sample that completes a
// window passes, once accepted, through the line RAM read-modify-write (registered
// read plus column merge), the cell chain update, the row product registers, the
// per-column sums and the final column total. Coefficient items are taken in
// stream order and apply to every later sample. The line RAM needs no clearing pass.
module conv2d_valid_window
  import c2dv_pkg::*;
#(
  parameter int MAX_KERNEL  = 5,
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // coef_index, coefficient, sample, zero fill
  input  logic [((COEF_IDX_W + COEF_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // command
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // conv_value, out_row, out_col, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int KSIZE   = MAX_KERNEL * MAX_KERNEL;
  localparam int SLOT_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int POS_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W   = ((POS_W > IMG_W) ? POS_W : IMG_W) + 1;
  localparam int WORD_W  = MAX_KERNEL * SAMPLE_BITS;
  localparam int SUM_W   = SAMPLE_BITS + COEF_W + $clog2(MAX_KERNEL);
  localparam int ACC_W   = SUM_W + $clog2(MAX_KERNEL);

  typedef logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] col_vec_t;

  function automatic logic [CMP_W-1:0] clamp_dim(logic [CMP_W-1:0] v, logic [CMP_W-1:0] hi);
    logic [CMP_W-1:0] res;
    if (v == '0) begin
      res = CMP_W'(1);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  logic [IMG_W-1:0]  img_cols_q, img_rows_q;
  logic [KDIM_W-1:0] kr_q, kc_q;
  logic [CMP_W-1:0]  cols_c, rows_c, kr_c, kc_c;

  logic [COL_W-1:0]  col_q, col_d, cur_col;
  logic [ROW_W-1:0]  row_q, row_d, cur_row;
  logic [SLOT_W-1:0] slot_q, slot_d, cur_slot, base_d;
  logic [CMP_W-1:0]  row1, col1, r0, c0, base_sum;
  logic              s_acc, in_sample, wrap, emit_d, fwd_d;
  res_meta_t         meta_d;

  logic              rdy1, rdy2, rdy3, rdy4, rdy5, s1_adv;
  logic              s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic              s1_sample_q, s1_emit_q, s1_fwd_q;
  logic [COL_W-1:0]  s1_col_q;
  logic [SLOT_W-1:0] s1_slot_q, s1_base_q;
  logic [SAMPLE_BITS-1:0] s1_sample_val_q;
  logic [COEF_IDX_W-1:0]  s1_cidx_q;
  logic [COEF_W-1:0]      s1_coef_q;
  res_meta_t         s1_meta_q, s2_meta_q, s3_meta_q, s4_meta_q, s5_meta_q;
  logic [CONV_W-1:0] s5_value_q;

  logic                  ram_we, ram_re;
  col_vec_t              ram_rdata, wr_word_q, phys, merged, rot;
  logic [SLOT_W:0]       ridx;

  logic                            kern_we;
  logic [KSIZE-1:0][COEF_W-1:0]    kern_q;

  cell_ctrl_t                         cell_ctrl;
  col_vec_t                           cell_col_in  [MAX_KERNEL];
  col_vec_t                           cell_col_out [MAX_KERNEL];
  logic [MAX_KERNEL-1:0][COEF_W-1:0]  cell_coef    [MAX_KERNEL];
  logic [MAX_KERNEL-1:0]              cell_row_en  [MAX_KERNEL];
  logic signed [SUM_W-1:0]            cell_sum     [MAX_KERNEL];
  logic signed [ACC_W-1:0]            total_d;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_cols_q <= IMG_COLS_RST;
      img_rows_q <= IMG_ROWS_RST;
      kr_q       <= KDIM_RST;
      kc_q       <= KDIM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_COLS:  img_cols_q <= cfg_data_i[IMG_W-1:0];
        CFG_IMAGE_ROWS:  img_rows_q <= cfg_data_i[IMG_W-1:0];
        CFG_KERNEL_ROWS: kr_q       <= cfg_data_i[KDIM_W-1:0];
        CFG_KERNEL_COLS: kc_q       <= cfg_data_i[KDIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cols_c = clamp_dim(CMP_W'(img_cols_q), CMP_W'(MAX_WIDTH));
  assign rows_c = clamp_dim(CMP_W'(img_rows_q), CMP_W'(MAX_HEIGHT));
  assign kr_c   = clamp_dim(CMP_W'(kr_q), CMP_W'(MAX_KERNEL));
  assign kc_c   = clamp_dim(CMP_W'(kc_q), CMP_W'(MAX_KERNEL));

  // handshake chain
  assign rdy5   = !s5_valid_q || m_axis_tready;
  assign rdy4   = !s4_valid_q || rdy5;
  assign rdy3   = !s3_valid_q || rdy4;
  assign rdy2   = !s2_valid_q || rdy3;
  assign rdy1   = !s1_valid_q || rdy2;
  assign s1_adv = s1_valid_q && rdy2;

  assign s_axis_tready = rdy1;
  assign s_acc         = s_axis_tvalid && rdy1;
  assign in_sample     = (s_axis_tuser == CMD_SAMPLE);

  // position and window decision for the incoming sample
  always_comb begin
    wrap     = (CMP_W'(row_q) >= rows_c) || (CMP_W'(col_q) >= cols_c);
    cur_row  = wrap ? '0 : row_q;
    cur_col  = wrap ? '0 : col_q;
    cur_slot = wrap ? '0 : slot_q;
    row1     = CMP_W'(cur_row) + CMP_W'(1);
    col1     = CMP_W'(cur_col) + CMP_W'(1);
    emit_d   = (kr_c <= rows_c) && (kc_c <= cols_c) && (row1 >= kr_c) && (col1 >= kc_c);
    r0       = row1 - kr_c;
    c0       = col1 - kc_c;
    meta_d.out_row    = r0[COORD_W-1:0];
    meta_d.out_col    = c0[COORD_W-1:0];
    meta_d.frame_last = (row1 == rows_c) && (col1 == cols_c);
    base_sum = CMP_W'(cur_slot) + CMP_W'(MAX_KERNEL) + CMP_W'(1) - kr_c;
    base_d   = (base_sum >= CMP_W'(MAX_KERNEL)) ? SLOT_W'(base_sum - CMP_W'(MAX_KERNEL))
                                                : SLOT_W'(base_sum);
    if (col1 >= cols_c) begin
      col_d = '0;
      if (row1 >= rows_c) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = ROW_W'(row1);
        slot_d = (cur_slot == SLOT_W'(MAX_KERNEL - 1)) ? '0 : cur_slot + SLOT_W'(1);
      end
    end else begin
      col_d  = COL_W'(col1);
      row_d  = cur_row;
      slot_d = cur_slot;
    end
  end

  assign ram_re = s_acc && in_sample;
  assign ram_we = s1_adv && s1_sample_q;
  assign fwd_d  = ram_we && (s1_col_q == cur_col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (s_acc && in_sample) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (rdy1) s1_valid_q <= s_axis_tvalid;
      if (rdy2) s2_valid_q <= s1_valid_q && s1_sample_q && s1_emit_q;
      if (rdy3) s3_valid_q <= s2_valid_q;
      if (rdy4) s4_valid_q <= s3_valid_q;
      if (rdy5) s5_valid_q <= s4_valid_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_sample_q     <= in_sample;
      s1_emit_q       <= emit_d;
      s1_fwd_q        <= fwd_d;
      s1_col_q        <= cur_col;
      s1_slot_q       <= cur_slot;
      s1_base_q       <= base_d;
      s1_meta_q       <= meta_d;
      s1_cidx_q       <= s_axis_tdata[COEF_IDX_W-1:0];
      s1_coef_q       <= s_axis_tdata[COEF_IDX_W +: COEF_W];
      s1_sample_val_q <= s_axis_tdata[COEF_IDX_W + COEF_W +: SAMPLE_BITS];
    end
    if (ram_we) begin
      wr_word_q <= merged;
    end
    if (rdy2 && s1_valid_q) s2_meta_q <= s1_meta_q;
    if (rdy3 && s2_valid_q) s3_meta_q <= s2_meta_q;
    if (rdy4 && s3_valid_q) s4_meta_q <= s3_meta_q;
    if (rdy5 && s4_valid_q) begin
      s5_meta_q  <= s4_meta_q;
      s5_value_q <= CONV_W'(total_d);
    end
  end

  // line RAM: one word per column, one sample per row slot
  c2dv_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (s1_col_q),
    .wr_data_i (merged),
    .rd_en_i   (ram_re),
    .rd_addr_i (cur_col),
    .rd_data_o (ram_rdata)
  );

  // merge the new sample into its slot, rotate slots into window row order
  always_comb begin
    ridx   = '0;
    phys   = s1_fwd_q ? wr_word_q : ram_rdata;
    merged = phys;
    merged[s1_slot_q] = s1_sample_val_q;
    for (int r = 0; r < MAX_KERNEL; r++) begin
      ridx = {1'b0, s1_base_q} + (SLOT_W + 1)'(r);
      if (ridx >= (SLOT_W + 1)'(MAX_KERNEL)) begin
        ridx = ridx - (SLOT_W + 1)'(MAX_KERNEL);
      end
      rot[r] = merged[ridx[SLOT_W-1:0]];
    end
  end

  // kernel store
  assign kern_we = s1_adv && !s1_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q <= '0;
    end else if (kern_we) begin
      for (int i = 0; i < KSIZE; i++) begin
        if (int'(s1_cidx_q) == i) begin
          kern_q[i] <= s1_coef_q;
        end
      end
    end
  end

  // cell chain: new column enters at the cell of the rightmost kernel column
  always_comb begin
    cell_ctrl.shift = ram_we;
    cell_ctrl.prod  = rdy3 && s2_valid_q;
    cell_ctrl.sum   = rdy4 && s3_valid_q;
    cell_col_in[MAX_KERNEL-1] = rot;
    for (int c = 0; c < MAX_KERNEL - 1; c++) begin
      cell_col_in[c] = (CMP_W'(c + 1) == kc_c) ? rot : cell_col_out[c + 1];
    end
    for (int c = 0; c < MAX_KERNEL; c++) begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
        cell_coef[c][r]   = kern_q[r * MAX_KERNEL + c];
        cell_row_en[c][r] = (CMP_W'(r) < kr_c) && (CMP_W'(c) < kc_c);
      end
    end
  end

  for (genvar c = 0; c < MAX_KERNEL; c++) begin : g_cell
    c2dv_cell #(
      .MAX_KERNEL  (MAX_KERNEL),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .col_i    (cell_col_in[c]),
      .coef_i   (cell_coef[c]),
      .row_en_i (cell_row_en[c]),
      .col_o    (cell_col_out[c]),
      .sum_o    (cell_sum[c])
    );
  end

  always_comb begin
    total_d = '0;
    for (int c = 0; c < MAX_KERNEL; c++) begin
      total_d = total_d + ACC_W'(cell_sum[c]);
    end
  end

  // result port
  assign m_axis_tvalid = s5_valid_q;
  assign m_axis_tlast  = s5_meta_q.frame_last;
  assign m_axis_tdata  = {(OUT_TDATA_W - CONV_W - 2 * COORD_W)'(0),
                          s5_meta_q.out_col, s5_meta_q.out_row, s5_value_q};

  `C2DV_ASSERT_IMP(a_slot_tracks_row, clk_i, rst_ni, 1'b1, 32'(slot_q) == (32'(row_q) % MAX_KERNEL))
  `C2DV_ASSERT_NXT(a_coef_item_no_result, clk_i, rst_ni, s1_adv && !s1_sample_q, !s2_valid_q)
  `C2DV_ASSERT_NXT(a_bad_index_ignored, clk_i, rst_ni, kern_we && (int'(s1_cidx_q) >= KSIZE), $stable(kern_q))

endmodule

`default_nettype wire
